// ----- rtl/scaled_bayer_dither_pixel_expander_core_defines.svh -----
// Assertion macros used by the pixel expander datapath.
`ifndef SCALED_BAYER_DITHER_PIXEL_EXPANDER_CORE_DEFINES_SVH
`define SCALED_BAYER_DITHER_PIXEL_EXPANDER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and idle while arst_n is low.
`define SBDPE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and idle while arst_n is low.
`define SBDPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sbdpe_pkg.sv -----
// Shared types, constants and functions of the pixel expander.
`timescale 1ns / 1ps
`default_nettype none
package sbdpe_pkg;

	localparam int SCALE_FRAC_BITS = 12;
	localparam int SCALE_W         = 15;
	localparam int COORD_W         = 11;
	localparam int SRC_W           = 12;
	localparam int COLOR_W         = 16;
	localparam int GRAY_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 15;
	localparam int IN_DATA_W       = 40;
	localparam int OUT_DATA_W      = 24;
	localparam int PROD_W          = SRC_W + 1 + SCALE_W;
	localparam int SPAN_W          = PROD_W - SCALE_FRAC_BITS + 1;
	localparam int MAX_SCALE       = 4 << SCALE_FRAC_BITS;
	localparam int UNIT_SCALE      = 1 << SCALE_FRAC_BITS;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y  = 3'd4;

	localparam logic [GRAY_W-1:0] BAYER_TBL [0:3][0:3] = '{
		'{8'd15,  8'd135, 8'd45,  8'd165},
		'{8'd195, 8'd75,  8'd225, 8'd105},
		'{8'd60,  8'd180, 8'd30,  8'd150},
		'{8'd240, 8'd120, 8'd210, 8'd90}
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic span;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last_pix;
		logic out_free;
	} sts_t;

	// RGB565 to 8-bit gray, weights 77/150/29 over 256
	function automatic logic [GRAY_W-1:0] gray_of(input logic [COLOR_W-1:0] color);
		logic [15:0] r8;
		logic [15:0] g8;
		logic [15:0] b8;
		logic [15:0] sum;
		r8  = {8'd0, color[15:11], 3'd0};
		g8  = {8'd0, color[10:5], 2'd0};
		b8  = {8'd0, color[4:0], 3'd0};
		sum = r8 * 16'd77 + g8 * 16'd150 + b8 * 16'd29;
		return sum[15:8];
	endfunction

	function automatic logic [GRAY_W-1:0] bayer_threshold(input logic [1:0] row,
		input logic [1:0] col);
		return BAYER_TBL[row][col];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sbdpe_ctrl.sv -----
// Controller state machine: accept, span setup and per-pixel emit sequencing.
`timescale 1ns / 1ps
`default_nettype none
module sbdpe_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sbdpe_pkg::sts_t  sts,
	output sbdpe_pkg::cmd_t       cmd
);

	sbdpe_pkg::state_t state_q;
	sbdpe_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbdpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sbdpe_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = sbdpe_pkg::ST_SPAN;
			end
			sbdpe_pkg::ST_SPAN: begin
				state_nxt = sts.empty ? sbdpe_pkg::ST_IDLE : sbdpe_pkg::ST_EMIT;
			end
			sbdpe_pkg::ST_EMIT: begin
				if (sts.out_free && sts.last_pix) state_nxt = sbdpe_pkg::ST_IDLE;
			end
			default: state_nxt = sbdpe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			sbdpe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sbdpe_pkg::ST_SPAN: begin
				cmd.span = 1'b1;
			end
			sbdpe_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/sbdpe_datapath.sv -----
// Datapath: products, span bounds, raster counters and the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_bayer_dither_pixel_expander_core_defines.svh"
module sbdpe_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sbdpe_pkg::cmd_t                       cmd,
	output sbdpe_pkg::sts_t                            sts,
	input  wire logic [sbdpe_pkg::SRC_W-1:0]           src_x,
	input  wire logic [sbdpe_pkg::SRC_W-1:0]           src_y,
	input  wire logic [sbdpe_pkg::COLOR_W-1:0]         color,
	input  wire logic [sbdpe_pkg::SCALE_W-1:0]         scale_q12,
	input  wire logic [sbdpe_pkg::COORD_W-1:0]         offset_x,
	input  wire logic [sbdpe_pkg::COORD_W-1:0]         offset_y,
	input  wire logic [sbdpe_pkg::COORD_W-1:0]         limit_x,
	input  wire logic [sbdpe_pkg::COORD_W-1:0]         limit_y,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [sbdpe_pkg::COORD_W-1:0]              pixel_x,
	output logic [sbdpe_pkg::COORD_W-1:0]              pixel_y,
	output logic                                       is_white,
	output logic                                       last
);

	localparam int PW = sbdpe_pkg::PROD_W;
	localparam int SW = sbdpe_pkg::SPAN_W;
	localparam int CW = sbdpe_pkg::COORD_W;
	localparam int FB = sbdpe_pkg::SCALE_FRAC_BITS;

	logic [sbdpe_pkg::SCALE_W-1:0] scale_c;
	logic [PW-1:0]                 px_s1;
	logic [PW-1:0]                 py_s1;
	logic [sbdpe_pkg::SCALE_W-1:0] scale_s1;
	logic [sbdpe_pkg::GRAY_W-1:0]  gray_s1;

	logic [PW-1:0] qx;
	logic [PW-1:0] qy;
	logic [SW-1:0] ax;
	logic [SW-1:0] bx;
	logic [SW-1:0] wx;
	logic [SW-1:0] cx1;
	logic [SW-1:0] ay;
	logic [SW-1:0] by;
	logic [SW-1:0] wy;
	logic [SW-1:0] cy1;

	logic [CW-1:0] x0_q;
	logic [CW-1:0] x1_q;
	logic [CW-1:0] y1_q;
	logic [CW-1:0] cx_q;
	logic [CW-1:0] cy_q;
	logic [CW-1:0] cx_inc;
	logic [CW-1:0] cy_inc;
	logic          row_end;
	logic          out_valid_q;
	logic [CW-1:0] pixel_x_q;
	logic [CW-1:0] pixel_y_q;
	logic          is_white_q;
	logic          last_q;

	// Saturate scale at 4.0
	assign scale_c = (scale_q12 > sbdpe_pkg::SCALE_W'(sbdpe_pkg::MAX_SCALE)) ?
		sbdpe_pkg::SCALE_W'(sbdpe_pkg::MAX_SCALE) : scale_q12;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_s1    <= PW'(src_x) * PW'(scale_c);
			py_s1    <= PW'(src_y) * PW'(scale_c);
			scale_s1 <= scale_c;
			gray_s1  <= sbdpe_pkg::gray_of(color);
		end
	end

	// Span end uses (c+1)*s = c*s + s, so one multiplier per axis suffices
	always_comb begin
		qx  = px_s1 + PW'(scale_s1);
		qy  = py_s1 + PW'(scale_s1);
		ax  = SW'(offset_x) + SW'(px_s1 >> FB);
		bx  = SW'(offset_x) + SW'(qx >> FB);
		ay  = SW'(offset_y) + SW'(py_s1 >> FB);
		by  = SW'(offset_y) + SW'(qy >> FB);
		wx  = (bx <= ax) ? ax + SW'(1) : bx;
		wy  = (by <= ay) ? ay + SW'(1) : by;
		cx1 = (wx > SW'(limit_x)) ? SW'(limit_x) : wx;
		cy1 = (wy > SW'(limit_y)) ? SW'(limit_y) : wy;
	end

	assign cx_inc  = cx_q + CW'(1);
	assign cy_inc  = cy_q + CW'(1);
	assign row_end = (cx_inc == x1_q);

	// Start column never falls below offset, so only the upper bound clips
	always_ff @(posedge clk) begin
		if (cmd.span) begin
			x0_q <= ax[CW-1:0];
			x1_q <= cx1[CW-1:0];
			y1_q <= cy1[CW-1:0];
			cx_q <= ax[CW-1:0];
			cy_q <= ay[CW-1:0];
		end else if (cmd.emit) begin
			if (row_end) begin
				cx_q <= x0_q;
				cy_q <= cy_inc;
			end else begin
				cx_q <= cx_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_x_q  <= cx_q;
			pixel_y_q  <= cy_q;
			is_white_q <= gray_s1 > sbdpe_pkg::bayer_threshold(cy_q[1:0], cx_q[1:0]);
			last_q     <= sts.last_pix;
		end
	end

	assign sts.empty    = (ax >= cx1) || (ay >= cy1);
	assign sts.last_pix = row_end && (cy_inc == y1_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign is_white  = is_white_q;
	assign last      = last_q;

	`SBDPE_ASSERT_IMPL(a_emit_slot_free, cmd.emit, !out_valid_q || out_ready, "emit over a held pixel")
	`SBDPE_ASSERT_IMPL(a_emit_in_rect, cmd.emit, (cx_q < x1_q) && (cy_q < y1_q), "raster left rectangle")
	`SBDPE_ASSERT_NEXT(a_span_nonempty, cmd.span && !sts.empty, (x0_q < x1_q) && (cy_q < y1_q), "empty span taken")

endmodule
`default_nettype wire

// ----- rtl/scaled_bayer_dither_pixel_expander_core.sv -----
// Top level of the scaled Bayer dither pixel expander: config registers and core wiring.
`timescale 1ns / 1ps
`default_nettype none
// Each transfer on s_axis carries one RGB565 source pixel with its source column and
// row. The pixel is reduced to 8-bit gray ((77*R8 + 150*G8 + 29*B8) >> 8), scaled by
// nearest neighbour into an output rectangle from offset + floor(coord*scale) up to
// offset + floor((coord+1)*scale), widened to at least one pixel, and clipped to
// [offset_x, limit_x) x [offset_y, limit_y). Every surviving pixel leaves on m_axis
// in row-major order as white when gray exceeds the 4x4 Bayer threshold at
// (y&3, x&3), black otherwise; tlast marks the final pixel of a source pixel, and a
// fully clipped source pixel produces no transfer at all. Scale is unsigned Q3.12
// (4096 = 1.0) and saturates at 4.0, so one source pixel yields at most 16 pixels.
// Sequence: accept the item and register the two coordinate products, then build and
// clip the rectangle, then emit one output pixel per cycle while m_axis takes them; a
// fully clipped item returns to idle after the rectangle step. s_axis_tready is high
// only between items, but the final pixel may still sit in the output register while
// the next item is taken. Write configuration through cfg_* only while the block is
// idle; cfg_ready is always high and indexes past limit_y are ignored.
module scaled_bayer_dither_pixel_expander_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [sbdpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sbdpe_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Source pixel stream
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [sbdpe_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // src_x, src_y, color
	// Output pixel stream
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic [sbdpe_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // pixel_x, pixel_y,
	                                                                 // is_white, zero pad
	output logic                                      m_axis_tlast
);

	localparam int CW = sbdpe_pkg::COORD_W;
	localparam int SR = sbdpe_pkg::SRC_W;

	logic [sbdpe_pkg::SCALE_W-1:0] scale_q12_q;
	logic [CW-1:0]                 offset_x_q;
	logic [CW-1:0]                 offset_y_q;
	logic [CW-1:0]                 limit_x_q;
	logic [CW-1:0]                 limit_y_q;

	sbdpe_pkg::cmd_t cmd;
	sbdpe_pkg::sts_t sts;

	logic [CW-1:0] pixel_x;
	logic [CW-1:0] pixel_y;
	logic          is_white;

	// Configuration registers: always ready, one register per transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q12_q <= sbdpe_pkg::SCALE_W'(sbdpe_pkg::UNIT_SCALE);
			offset_x_q  <= '0;
			offset_y_q  <= '0;
			limit_x_q   <= '0;
			limit_y_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbdpe_pkg::REG_SCALE:    scale_q12_q <= cfg_data[sbdpe_pkg::SCALE_W-1:0];
				sbdpe_pkg::REG_OFFSET_X: offset_x_q  <= cfg_data[CW-1:0];
				sbdpe_pkg::REG_OFFSET_Y: offset_y_q  <= cfg_data[CW-1:0];
				sbdpe_pkg::REG_LIMIT_X:  limit_x_q   <= cfg_data[CW-1:0];
				sbdpe_pkg::REG_LIMIT_Y:  limit_y_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	sbdpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbdpe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.src_x     (s_axis_tdata[SR-1:0]),
		.src_y     (s_axis_tdata[2*SR-1:SR]),
		.color     (s_axis_tdata[2*SR+sbdpe_pkg::COLOR_W-1:2*SR]),
		.scale_q12 (scale_q12_q),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.limit_x   (limit_x_q),
		.limit_y   (limit_y_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.is_white  (is_white),
		.last      (m_axis_tlast)
	);

	// Pack pixel_x low, then pixel_y, then is_white; pad to a whole byte
	assign m_axis_tdata = sbdpe_pkg::OUT_DATA_W'({is_white, pixel_y, pixel_x});

endmodule
`default_nettype wire
